[hdl/etcs_pkg.sv]
// Shared types, widths and codes for the escape-time count smoothing block.
// Used by the channel interfaces, the logarithm and divider chains, and the top level.
`default_nettype none

package etcs_pkg;

   localparam int ITER_W      = 16;
   localparam int RADIUS_W    = 32;
   localparam int POW_W       = 48;
   localparam int LOG_W       = 32;
   localparam int COUNT_W     = 48;
   localparam int STATUS_W    = 2;
   localparam int CSR_DATA_W  = 48;
   localparam int CSR_INDEX_W = 3;

   // Logarithm datapath: Q1.31 mantissa, 32 fraction bits of log2, small exponent.
   localparam int MANT_W = 32;
   localparam int FRAC_W = 32;
   localparam int EXP_W  = 6;

   // Divider: 64-bit dividend, 48-bit divisor, 49 quotient bits.
   localparam int DIVIDEND_W = 64;
   localparam int DEN_W      = 48;
   localparam int QUOT_W     = 49;
   localparam int DIV_LAT    = QUOT_W + 1;

   localparam logic [23:0] LN2_Q24 = 24'd11629080;

   localparam logic signed [COUNT_W-1:0] COUNT_MAX = 48'sh7FFF_FFFF_FFFF;

   typedef enum logic [1:0] {
      MODE_DISCRETE   = 2'd0,
      MODE_CONTINUOUS = 2'd1,
      MODE_SMOOTH     = 2'd2
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK           = 2'd0,
      STATUS_ZERO_DIVISOR = 2'd1,
      STATUS_LOG_DOMAIN   = 2'd2
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MODE              = 3'd0,
      CSR_ESCAPE_RADIUS     = 3'd1,
      CSR_ESCAPE_RADIUS_POW = 3'd2,
      CSR_LOG_ESCAPE_RADIUS = 3'd3,
      CSR_LOG_NORM_P        = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [MANT_W-1:0]       mant;
      logic [FRAC_W-1:0]       frac;
      logic signed [EXP_W-1:0] expo;
   } log_state_type;

   typedef struct packed {
      logic [DEN_W-1:0]  rem;
      logic [QUOT_W-1:0] dq;
      logic [DEN_W-1:0]  den;
      logic              ovf;
   } div_state_type;

   // Position of the highest set bit; zero for a zero argument.
   function automatic logic [4:0] msb_index(input logic [31:0] x);
      logic [4:0] idx;
      idx = '0;
      for (int i = 0; i < 32; i++) begin
         if (x[i]) begin
            idx = 5'(i);
         end
      end
      return idx;
   endfunction

endpackage

`default_nettype wire

[hdl/etcs_req_if.sv]
// Input channel of the escape-time count smoothing block: valid/ready and one item.
// Depends on etcs_pkg for the field widths.
`default_nettype none

interface etcs_req_if import etcs_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ITER_W-1:0]   iter_count;
   logic [RADIUS_W-1:0] orbit_radius;

   modport source (output valid, output iter_count, output orbit_radius, input ready);
   modport sink   (input valid, input iter_count, input orbit_radius, output ready);
endinterface

`default_nettype wire

[hdl/etcs_rsp_if.sv]
// Result channel of the escape-time count smoothing block: valid/ready and one item.
// Depends on etcs_pkg for the field widths.
`default_nettype none

interface etcs_rsp_if import etcs_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COUNT_W-1:0] count_value;
   logic [STATUS_W-1:0]       status;

   modport source (output valid, output count_value, output status, input ready);
   modport sink   (input valid, input count_value, input status, output ready);
endinterface

`default_nettype wire

[hdl/etcs_sq_cell.sv]
// One squaring step of the binary logarithm: yields one fraction bit of log2.
// Depends on etcs_pkg for log_state_type.
`default_nettype none

module etcs_sq_cell import etcs_pkg::*; #(
   parameter int STEP = 1
) (
   input  logic          clock,
   input  logic          en,
   input  log_state_type cur,
   output log_state_type state_ff
);

   logic [2*MANT_W-1:0] square;
   logic [MANT_W:0]     scaled;
   log_state_type       state_in;

   always_comb begin
      square   = {{MANT_W{1'b0}}, cur.mant} * {{MANT_W{1'b0}}, cur.mant};
      scaled   = square[2*MANT_W-1:MANT_W-1];
      state_in = cur;
      // A square of 2.0 or more means this fraction bit is set; renormalize.
      if (scaled[MANT_W]) begin
         state_in.mant                = scaled[MANT_W:1];
         state_in.frac[FRAC_W - STEP] = 1'b1;
      end else begin
         state_in.mant = scaled[MANT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[hdl/etcs_log.sv]
// Pipelined natural logarithm of an unsigned Q16.16 value, result signed Q16.16.
// Depends on etcs_pkg and etcs_sq_cell; registers advance only while en is high.
`default_nettype none

module etcs_log import etcs_pkg::*; #(
   parameter int ITERATIONS = 16
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic [31:0]             arg,
   output logic signed [LOG_W-1:0] ln_value
);

   localparam logic [53:0] ROUND_HALF = 54'd1 << 31;

   log_state_type stage0_ff;
   log_state_type chain [0:ITERATIONS];
   logic [4:0]    msb;

   logic [37:0] l2;
   logic [37:0] l2_neg;
   logic [37:0] l2_mag;
   logic [29:0] mag_ff;
   logic        neg_ff;
   logic [53:0] scaled;
   logic [21:0] result_ff;
   logic        result_neg_ff;
   logic [31:0] result_ext;

   assign msb = msb_index(arg);

   // Normalize so the leading one sits at bit 31.
   always_ff @(posedge clock) begin
      if (en) begin
         stage0_ff.mant <= arg << (5'd31 - msb);
         stage0_ff.frac <= '0;
         stage0_ff.expo <= $signed({1'b0, msb}) - 6'sd16;
      end
   end

   assign chain[0] = stage0_ff;

   for (genvar k = 1; k <= ITERATIONS; k++) begin : g_cell
      etcs_sq_cell #(.STEP(k)) u_cell (
         .clock    (clock),
         .en       (en),
         .cur      (chain[k-1]),
         .state_ff (chain[k])
      );
   end

   // Exponent and fraction together form log2 in Q32.
   always_comb begin
      l2     = {chain[ITERATIONS].expo, chain[ITERATIONS].frac};
      l2_neg = -l2;
      l2_mag = l2[37] ? l2_neg : l2;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff <= l2_mag[37:8];
         neg_ff <= l2[37];
      end
   end

   assign scaled = {24'd0, mag_ff} * {30'd0, LN2_Q24} + ROUND_HALF;

   always_ff @(posedge clock) begin
      if (en) begin
         result_ff     <= scaled[53:32];
         result_neg_ff <= neg_ff;
      end
   end

   assign result_ext = {10'd0, result_ff};
   assign ln_value   = result_neg_ff ? -$signed(result_ext) : $signed(result_ext);

endmodule

`default_nettype wire

[hdl/etcs_div_cell.sv]
// One restoring-division step: shifts in a dividend bit and produces one quotient bit.
// Depends on etcs_pkg for div_state_type.
`default_nettype none

module etcs_div_cell import etcs_pkg::*; (
   input  logic          clock,
   input  logic          en,
   input  div_state_type cur,
   output div_state_type state_ff
);

   logic [DEN_W:0] trial;
   logic [DEN_W:0] diff;
   logic           ge;
   div_state_type  state_in;

   always_comb begin
      trial    = {cur.rem, cur.dq[QUOT_W-1]};
      diff     = trial - {1'b0, cur.den};
      ge       = trial >= {1'b0, cur.den};
      state_in = cur;
      state_in.rem = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      state_in.dq  = {cur.dq[QUOT_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[hdl/etcs_div.sv]
// Pipelined unsigned divider, 64-bit dividend by 48-bit divisor, 49 quotient bits.
// Depends on etcs_pkg and etcs_div_cell; an input register and the division cells, all advancing only while en is high.
`default_nettype none

module etcs_div import etcs_pkg::*; (
   input  logic                  clock,
   input  logic                  en,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DEN_W-1:0]      divisor,
   output logic [QUOT_W-1:0]     quotient,
   output logic                  overflow
);

   localparam int HIGH_W = DIVIDEND_W - QUOT_W;

   div_state_type  stage0_ff;
   div_state_type  chain [0:QUOT_W];
   logic [DEN_W-1:0] high_part;

   assign high_part = {{(DEN_W - HIGH_W){1'b0}}, dividend[DIVIDEND_W-1:QUOT_W]};

   // A quotient of 2^49 or more cannot be formed by the chain; it is flagged instead.
   always_ff @(posedge clock) begin
      if (en) begin
         stage0_ff.rem <= high_part;
         stage0_ff.dq  <= dividend[QUOT_W-1:0];
         stage0_ff.den <= divisor;
         stage0_ff.ovf <= high_part >= divisor;
      end
   end

   assign chain[0] = stage0_ff;

   for (genvar k = 1; k <= QUOT_W; k++) begin : g_cell
      etcs_div_cell u_cell (
         .clock    (clock),
         .en       (en),
         .cur      (chain[k-1]),
         .state_ff (chain[k])
      );
   end

   assign quotient = chain[QUOT_W].dq;
   assign overflow = chain[QUOT_W].ovf;

endmodule

`default_nettype wire

[hdl/escape_time_count_smoothing.sv]
// Top level of the escape-time count smoothing block.
// Depends on etcs_pkg, etcs_req_if, etcs_rsp_if, etcs_log and etcs_div.
//
// Usage: each item on req_chan carries an integer iteration count and the orbit
// radius (unsigned Q16.16) of one pixel. The block returns one item on rsp_chan per
// input item, in order: a fractional count in signed Q32.16 and a status code.
// The csr_ port writes the mode and the radius/log constants; write them only while
// no item is in flight.
//
// Every item walks the same fixed pipeline: a logarithm chain on the radius, two
// logarithm chains in parallel on the log values, then a restoring divider with one
// quotient bit per stage. The pipeline is 2*LOG_ITERATIONS + 62 registers deep, and
// throughput is one item per cycle while rsp_chan takes results; each logarithm
// cell holds one 32x32 squaring.
//
// When rsp_chan stalls, a skid register takes one more result, then the whole
// pipeline freezes and req_chan.ready drops until the skid register drains.
// Reset (synchronous) empties the pipeline and restores the register defaults.
`default_nettype none

module escape_time_count_smoothing import etcs_pkg::*; #(
   parameter int LOG_ITERATIONS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   etcs_req_if.sink               req_chan,
   etcs_rsp_if.source             rsp_chan,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   localparam int LOG_LAT = LOG_ITERATIONS + 3;

   localparam logic [POW_W-1:0]      POW_RESET    = 48'd262144;
   localparam logic [RADIUS_W-1:0]   RADIUS_RESET = 32'd131072;
   localparam logic signed [LOG_W-1:0] LOG_RESET  = 32'sd45426;
   localparam logic [QUOT_W-1:0]     QUOT_LIMIT   = 49'd1 << 48;
   localparam logic signed [50:0]    SUM_MAX      = 51'sd140737488355327;
   localparam logic signed [50:0]    SUM_MIN      = -51'sd140737488355328;

   typedef struct packed {
      logic [ITER_W-1:0]   n;
      logic [RADIUS_W-1:0] r;
   } a_side_type;

   typedef struct packed {
      logic [ITER_W-1:0]   n;
      logic [RADIUS_W-1:0] r;
      status_type          st;
   } b_side_type;

   typedef struct packed {
      status_type  st;
      logic        neg;
      logic        use_q;
      logic [32:0] base;
   } c_side_type;

   // Configuration registers.
   logic [1:0]              mode_ff;
   logic [RADIUS_W-1:0]     radius_ff;
   logic [POW_W-1:0]        radius_pow_ff;
   logic signed [LOG_W-1:0] log_radius_ff;
   logic signed [LOG_W-1:0] log_p_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_DISCRETE;
         radius_ff     <= RADIUS_RESET;
         radius_pow_ff <= POW_RESET;
         log_radius_ff <= LOG_RESET;
         log_p_ff      <= LOG_RESET;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_MODE:              mode_ff       <= csr_write_data[1:0];
            CSR_ESCAPE_RADIUS:     radius_ff     <= csr_write_data[RADIUS_W-1:0];
            CSR_ESCAPE_RADIUS_POW: radius_pow_ff <= csr_write_data[POW_W-1:0];
            CSR_LOG_ESCAPE_RADIUS: log_radius_ff <= $signed(csr_write_data[LOG_W-1:0]);
            CSR_LOG_NORM_P:        log_p_ff      <= $signed(csr_write_data[LOG_W-1:0]);
            default: begin
            end
         endcase
      end
   end

   // The whole pipeline moves together; it only stops while the skid register is full.
   logic en;
   logic skid_v_ff;

   assign en             = !skid_v_ff;
   assign req_chan.ready = en;

   // Stage T0: input register.
   logic                t0_v_ff;
   logic [ITER_W-1:0]   t0_n_ff;
   logic [RADIUS_W-1:0] t0_r_ff;

   // Logarithm of the orbit radius.
   logic signed [LOG_W-1:0] ln_r;
   etcs_log #(.ITERATIONS(LOG_ITERATIONS)) u_log_radius (
      .clock    (clock),
      .en       (en),
      .arg      (t0_r_ff),
      .ln_value (ln_r)
   );

   logic [LOG_LAT-1:0] a_v_ff;
   a_side_type         a_line [0:LOG_LAT-1];

   // Stage T1: ln r and the smooth-mode domain checks.
   logic                    t1_v_ff;
   logic [ITER_W-1:0]       t1_n_ff;
   logic [RADIUS_W-1:0]     t1_r_ff;
   logic signed [LOG_W-1:0] t1_lnr_ff;
   status_type              t1_st_ff;
   status_type              st1;

   always_comb begin
      if (a_line[LOG_LAT-1].r == '0) begin
         st1 = STATUS_LOG_DOMAIN;
      end else if (ln_r == '0) begin
         st1 = STATUS_ZERO_DIVISOR;
      end else if (log_radius_ff == '0 || (log_radius_ff[LOG_W-1] != ln_r[LOG_W-1])) begin
         st1 = STATUS_LOG_DOMAIN;
      end else if (log_p_ff == '0) begin
         st1 = STATUS_ZERO_DIVISOR;
      end else begin
         st1 = STATUS_OK;
      end
   end

   // ln(lnR / ln r) is formed as ln|lnR| - ln|ln r|, with both logs in parallel.
   logic [LOG_W-1:0]        lnr_mag;
   logic [LOG_W-1:0]        lr_mag;
   logic signed [LOG_W-1:0] ln_lnr;
   logic signed [LOG_W-1:0] ln_lr;

   assign lnr_mag = t1_lnr_ff[LOG_W-1] ? (~t1_lnr_ff + 1'b1) : t1_lnr_ff;
   assign lr_mag  = log_radius_ff[LOG_W-1] ? (~log_radius_ff + 1'b1) : log_radius_ff;

   etcs_log #(.ITERATIONS(LOG_ITERATIONS)) u_log_lnr (
      .clock    (clock),
      .en       (en),
      .arg      (lnr_mag),
      .ln_value (ln_lnr)
   );

   etcs_log #(.ITERATIONS(LOG_ITERATIONS)) u_log_lr (
      .clock    (clock),
      .en       (en),
      .arg      (lr_mag),
      .ln_value (ln_lr)
   );

   logic [LOG_LAT-1:0] b_v_ff;
   b_side_type         b_line [0:LOG_LAT-1];

   // Stage T2: log difference and the continuous-mode numerator and denominator.
   logic                  t2_v_ff;
   logic [ITER_W-1:0]     t2_n_ff;
   status_type            t2_st_ff;
   logic signed [LOG_W:0] t2_d_ff;
   logic signed [POW_W:0] t2_num_ff;
   logic signed [POW_W:0] t2_den_ff;

   // Stage T3: divider operands.
   logic                  t3_v_ff;
   logic [DIVIDEND_W-1:0] t3_dividend_ff;
   logic [DEN_W-1:0]      t3_divisor_ff;
   c_side_type            t3_side_ff;

   logic [POW_W:0]        num_neg;
   logic [POW_W:0]        den_neg;
   logic [LOG_W:0]        d_neg;
   logic [POW_W-1:0]      num_mag;
   logic [POW_W-1:0]      den_mag;
   logic [LOG_W-1:0]      d_mag;
   logic [LOG_W-1:0]      p_mag;
   logic [32:0]           base0;
   logic [DIVIDEND_W-1:0] dividend3;
   logic [DEN_W-1:0]      divisor3;
   c_side_type            side3;

   always_comb begin
      num_neg = -t2_num_ff;
      den_neg = -t2_den_ff;
      d_neg   = -t2_d_ff;
      num_mag = t2_num_ff[POW_W] ? num_neg[POW_W-1:0] : t2_num_ff[POW_W-1:0];
      den_mag = t2_den_ff[POW_W] ? den_neg[POW_W-1:0] : t2_den_ff[POW_W-1:0];
      d_mag   = t2_d_ff[LOG_W] ? d_neg[LOG_W-1:0] : t2_d_ff[LOG_W-1:0];
      p_mag   = log_p_ff[LOG_W-1] ? (~log_p_ff + 1'b1) : log_p_ff;
      base0   = {1'b0, t2_n_ff, 16'd0};

      dividend3   = '0;
      divisor3    = '0;
      side3.st    = STATUS_OK;
      side3.neg   = 1'b0;
      side3.use_q = 1'b0;
      side3.base  = base0;

      case (mode_ff)
         MODE_CONTINUOUS: begin
            dividend3   = {num_mag, 16'd0};
            divisor3    = den_mag;
            side3.neg   = t2_num_ff[POW_W] ^ t2_den_ff[POW_W];
            side3.use_q = 1'b1;
            side3.st    = (t2_den_ff == '0) ? STATUS_ZERO_DIVISOR : STATUS_OK;
         end
         MODE_SMOOTH: begin
            dividend3   = {16'd0, d_mag, 16'd0};
            divisor3    = {16'd0, p_mag};
            side3.neg   = t2_d_ff[LOG_W] ^ log_p_ff[LOG_W-1];
            side3.use_q = 1'b1;
            side3.st    = t2_st_ff;
            side3.base  = base0 + 33'd65536;
         end
         default: begin
         end
      endcase
   end

   logic [QUOT_W-1:0] quot;
   logic              quot_ovf;

   etcs_div u_div (
      .clock    (clock),
      .en       (en),
      .dividend (t3_dividend_ff),
      .divisor  (t3_divisor_ff),
      .quotient (quot),
      .overflow (quot_ovf)
   );

   logic [DIV_LAT-1:0] c_v_ff;
   c_side_type         c_line [0:DIV_LAT-1];

   // Stage T4: clamp the quotient, add it to or subtract it from the integer count, and saturate.
   logic                      t4_v_ff;
   logic signed [COUNT_W-1:0] t4_count_ff;
   status_type                t4_status_ff;

   logic [QUOT_W-1:0]         q_clamped;
   logic signed [50:0]        base_s;
   logic signed [50:0]        q_s;
   logic signed [50:0]        sum;
   logic signed [50:0]        sum_sat;
   logic signed [COUNT_W-1:0] count4;
   c_side_type                side4;

   always_comb begin
      side4     = c_line[DIV_LAT-1];
      q_clamped = (quot_ovf || quot > QUOT_LIMIT) ? QUOT_LIMIT : quot;
      base_s    = $signed({18'd0, side4.base});
      q_s       = $signed({2'd0, q_clamped});
      if (!side4.use_q) begin
         sum = base_s;
      end else if (side4.neg) begin
         sum = base_s - q_s;
      end else begin
         sum = base_s + q_s;
      end
      if (sum > SUM_MAX) begin
         sum_sat = SUM_MAX;
      end else if (sum < SUM_MIN) begin
         sum_sat = SUM_MIN;
      end else begin
         sum_sat = sum;
      end
      // Any error reports the largest positive count.
      count4 = (side4.st != STATUS_OK) ? COUNT_MAX : sum_sat[COUNT_W-1:0];
   end

   // Valid bits of all stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         t0_v_ff <= 1'b0;
         a_v_ff  <= '0;
         t1_v_ff <= 1'b0;
         b_v_ff  <= '0;
         t2_v_ff <= 1'b0;
         t3_v_ff <= 1'b0;
         c_v_ff  <= '0;
         t4_v_ff <= 1'b0;
      end else if (en) begin
         t0_v_ff <= req_chan.valid;
         a_v_ff  <= {a_v_ff[LOG_LAT-2:0], t0_v_ff};
         t1_v_ff <= a_v_ff[LOG_LAT-1];
         b_v_ff  <= {b_v_ff[LOG_LAT-2:0], t1_v_ff};
         t2_v_ff <= b_v_ff[LOG_LAT-1];
         t3_v_ff <= t2_v_ff;
         c_v_ff  <= {c_v_ff[DIV_LAT-2:0], t3_v_ff};
         t4_v_ff <= c_v_ff[DIV_LAT-1];
      end
   end

   // Payload of all stages.
   always_ff @(posedge clock) begin
      if (en) begin
         t0_n_ff <= req_chan.iter_count;
         t0_r_ff <= req_chan.orbit_radius;

         a_line[0] <= '{n: t0_n_ff, r: t0_r_ff};
         for (int k = 1; k < LOG_LAT; k++) begin
            a_line[k] <= a_line[k-1];
         end

         t1_n_ff   <= a_line[LOG_LAT-1].n;
         t1_r_ff   <= a_line[LOG_LAT-1].r;
         t1_lnr_ff <= ln_r;
         t1_st_ff  <= st1;

         b_line[0] <= '{n: t1_n_ff, r: t1_r_ff, st: t1_st_ff};
         for (int k = 1; k < LOG_LAT; k++) begin
            b_line[k] <= b_line[k-1];
         end

         t2_n_ff   <= b_line[LOG_LAT-1].n;
         t2_st_ff  <= b_line[LOG_LAT-1].st;
         t2_d_ff   <= {ln_lr[LOG_W-1], ln_lr} - {ln_lnr[LOG_W-1], ln_lnr};
         t2_num_ff <= $signed({1'b0, radius_pow_ff})
                    - $signed({17'd0, b_line[LOG_LAT-1].r});
         t2_den_ff <= $signed({1'b0, radius_pow_ff}) - $signed({17'd0, radius_ff});

         t3_dividend_ff <= dividend3;
         t3_divisor_ff  <= divisor3;
         t3_side_ff     <= side3;

         c_line[0] <= t3_side_ff;
         for (int k = 1; k < DIV_LAT; k++) begin
            c_line[k] <= c_line[k-1];
         end

         t4_count_ff  <= count4;
         t4_status_ff <= side4.st;
      end
   end

   // Output register with a skid register behind it.
   logic                      out_v_ff;
   logic signed [COUNT_W-1:0] out_count_ff;
   status_type                out_status_ff;
   logic signed [COUNT_W-1:0] skid_count_ff;
   status_type                skid_status_ff;
   logic                      take;
   logic                      fin_fire;

   assign take     = out_v_ff && rsp_chan.ready;
   assign fin_fire = t4_v_ff && en;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (!out_v_ff || take) begin
         if (skid_v_ff) begin
            out_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            out_v_ff <= fin_fire;
         end
      end else if (fin_fire) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_v_ff || take) begin
         if (skid_v_ff) begin
            out_count_ff  <= skid_count_ff;
            out_status_ff <= skid_status_ff;
         end else begin
            out_count_ff  <= t4_count_ff;
            out_status_ff <= t4_status_ff;
         end
      end
      if (!skid_v_ff) begin
         skid_count_ff  <= t4_count_ff;
         skid_status_ff <= t4_status_ff;
      end
   end

   assign rsp_chan.valid       = out_v_ff;
   assign rsp_chan.count_value = out_count_ff;
   assign rsp_chan.status      = out_status_ff;

   // The skid register only fills behind a waiting result.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid register full while output register empty");

   // Every error result carries the saturated positive count.
   a_error_saturates: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status != STATUS_OK) |-> rsp_chan.count_value == COUNT_MAX)
      else $error("error result without saturated count");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.status == STATUS_OK
                          || rsp_chan.status == STATUS_ZERO_DIVISOR
                          || rsp_chan.status == STATUS_LOG_DOMAIN))
      else $error("undefined status code on result");

   // Discrete counting never yields a fraction or an error.
   a_discrete_whole: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && mode_ff != MODE_CONTINUOUS && mode_ff != MODE_SMOOTH)
      |-> (rsp_chan.count_value[15:0] == '0 && rsp_chan.status == STATUS_OK))
      else $error("discrete result with fraction or error");

endmodule

`default_nettype wire

[sim/tb_escape_time_count_smoothing.sv]
// Self-checking testbench for escape_time_count_smoothing: directed and random items.
// Depends on etcs_pkg, etcs_req_if, etcs_rsp_if and the block under test.
// A local fixed-point model predicts each result, and a scoreboard checks every result in order.
`default_nettype none

module tb_escape_time_count_smoothing;
   import etcs_pkg::*;

   localparam int LOG_ITERATIONS = 16;
   localparam int IDLE_LIMIT     = 3000;
   localparam int DRAIN_CYCLES   = 200;
   localparam longint MAX48      = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint MIN48      = -64'sh0000_8000_0000_0000;

   typedef struct {
      logic [COUNT_W-1:0] count_value;
      status_type         status;
   } smooth_result_type;

   logic clock;
   logic reset;
   logic csr_write_en;
   csr_index_type csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   etcs_req_if req_chan ();
   etcs_rsp_if rsp_chan ();

   escape_time_count_smoothing #(.LOG_ITERATIONS(LOG_ITERATIONS)) dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   // Local copy of the configuration registers, as they are after reset.
   logic [1:0]         cfg_mode = MODE_DISCRETE;
   logic [31:0]        cfg_radius = 32'd131072;
   logic [47:0]        cfg_radius_pow = 48'd262144;
   logic signed [31:0] cfg_log_radius = 32'sd45426;
   logic signed [31:0] cfg_log_p = 32'sd45426;

   smooth_result_type pending_counts[$];
   bit   failed = 1'b0;
   bit   steady_send;
   bit   steady_recv;
   int   burst_left;
   int   idle_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // Fixed-point model of the block.
   // ---------------------------------------------------------------------------

   function automatic logic [63:0] magnitude(input longint v);
      return (v < 0) ? 64'(-v) : 64'(v);
   endfunction

   function automatic longint clamp_count(input longint v);
      if (v > MAX48) begin
         return MAX48;
      end
      if (v < MIN48) begin
         return MIN48;
      end
      return v;
   endfunction

   // Natural log of a positive Q16.16 value, in Q16.16. The mantissa is squared
   // once per fraction bit of log2, then the binary log is scaled by ln 2.
   function automatic longint natural_log(input logic [63:0] x);
      int          msb;
      logic [63:0] mant;
      logic [63:0] frac;
      logic [63:0] scaled;
      logic [63:0] rounded;
      longint      log2_q32;
      msb = 63;
      while (msb > 0 && !x[msb]) begin
         msb--;
      end
      mant = (msb > 31) ? (x >> (msb - 31)) : (x << (31 - msb));
      frac = '0;
      for (int i = 1; i <= LOG_ITERATIONS && i <= 32; i++) begin
         mant = (mant * mant) >> 31;
         if (mant >= 64'h1_0000_0000) begin
            mant = mant >> 1;
            frac = frac | (64'd1 << (32 - i));
         end
      end
      log2_q32 = longint'(msb - 16) * 64'sd4294967296 + longint'(frac);
      scaled   = magnitude(log2_q32) >> 8;
      rounded  = (scaled * 64'(LN2_Q24) + (64'd1 << 31)) >> 32;
      return (log2_q32 < 0) ? -longint'(rounded) : longint'(rounded);
   endfunction

   function automatic smooth_result_type predict_count(input logic [15:0] iter_count,
                                                       input logic [31:0] orbit_radius);
      smooth_result_type res;
      longint      value;
      longint      num;
      longint      den;
      longint      ln_orbit;
      longint      ln_escape;
      longint      ln_diff;
      logic [63:0] quot;
      value = longint'(iter_count) * 65536;
      res.status = STATUS_OK;
      if (cfg_mode == MODE_CONTINUOUS) begin
         num = longint'(cfg_radius_pow) - longint'(orbit_radius);
         den = longint'(cfg_radius_pow) - longint'(cfg_radius);
         if (den == 0) begin
            res.status = STATUS_ZERO_DIVISOR;
         end else begin
            quot = (magnitude(num) << 16) / magnitude(den);
            if (quot > (64'd1 << 48)) begin
               quot = 64'd1 << 48;
            end
            value = clamp_count(value + (((num < 0) != (den < 0)) ? -longint'(quot)
                                                                  : longint'(quot)));
         end
      end else if (cfg_mode == MODE_SMOOTH) begin
         if (orbit_radius == 0) begin
            res.status = STATUS_LOG_DOMAIN;
         end else begin
            ln_orbit  = natural_log(64'(orbit_radius));
            ln_escape = longint'(cfg_log_radius);
            if (ln_orbit == 0) begin
               res.status = STATUS_ZERO_DIVISOR;
            end else if (ln_escape == 0 || ((ln_escape < 0) != (ln_orbit < 0))) begin
               res.status = STATUS_LOG_DOMAIN;
            end else if (cfg_log_p == 0) begin
               res.status = STATUS_ZERO_DIVISOR;
            end else begin
               // ln(lnR / ln r) is taken as a difference of logs of magnitudes.
               ln_diff = natural_log(magnitude(ln_escape)) - natural_log(magnitude(ln_orbit));
               quot = (magnitude(ln_diff) << 16) / magnitude(longint'(cfg_log_p));
               if (quot > (64'd1 << 48)) begin
                  quot = 64'd1 << 48;
               end
               value = clamp_count(value + 65536 +
                                   (((ln_diff < 0) != (cfg_log_p < 0)) ? -longint'(quot)
                                                                       : longint'(quot)));
            end
         end
      end
      // Any error saturates the count to the largest positive value.
      if (res.status != STATUS_OK) begin
         value = MAX48;
      end
      res.count_value = value[47:0];
      return res;
   endfunction

   // ---------------------------------------------------------------------------
   // Driving, result checking and the watchdog.
   // ---------------------------------------------------------------------------

   // Sends one item in bursts of random length. The item is accepted at the first
   // edge with ready high, and its expected result is queued at that moment.
   task automatic send_item(input logic [15:0] iter_count, input logic [31:0] orbit_radius);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = steady_send ? 0 : $urandom_range(0, 7);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_chan.valid        <= 1'b1;
      req_chan.iter_count   <= iter_count;
      req_chan.orbit_radius <= orbit_radius;
      do begin
         @(posedge clock);
      end while (!req_chan.ready);
      pending_counts.push_back(predict_count(iter_count, orbit_radius));
   endtask

   // Waits until every expected result has come back, with the sender idle.
   task automatic drain;
      req_chan.valid <= 1'b0;
      burst_left = 0;
      while (pending_counts.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   // Writes one register; only called while the pipeline is empty.
   task automatic write_csr(input csr_index_type index, input logic [47:0] data);
      csr_write_en   <= 1'b1;
      csr_index      <= index;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (index)
         CSR_MODE:              cfg_mode = data[1:0];
         CSR_ESCAPE_RADIUS:     cfg_radius = data[31:0];
         CSR_ESCAPE_RADIUS_POW: cfg_radius_pow = data[47:0];
         CSR_LOG_ESCAPE_RADIUS: cfg_log_radius = data[31:0];
         CSR_LOG_NORM_P:        cfg_log_p = data[31:0];
         default: begin
         end
      endcase
   endtask

   task automatic set_config(input logic [1:0] mode, input logic [31:0] radius,
                             input logic [47:0] radius_pow, input logic [31:0] log_radius,
                             input logic [31:0] log_p);
      drain();
      write_csr(CSR_MODE, 48'(mode));
      write_csr(CSR_ESCAPE_RADIUS, 48'(radius));
      write_csr(CSR_ESCAPE_RADIUS_POW, radius_pow);
      write_csr(CSR_LOG_ESCAPE_RADIUS, 48'(log_radius));
      write_csr(CSR_LOG_NORM_P, 48'(log_p));
   endtask

   // The receiver stalls on its own pattern: runs of ready and stall of random
   // length, with stretches where it never stalls.
   int recv_run;
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         recv_run <= 0;
      end else if (recv_run == 0) begin
         recv_run <= $urandom_range(1, 12);
         rsp_chan.ready <= steady_recv ? 1'b1 : ($urandom_range(0, 2) != 0);
      end else begin
         recv_run <= recv_run - 1;
      end
   end

   // Compares each accepted result with the oldest expectation.
   always @(posedge clock) begin
      smooth_result_type exp_res;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_counts.size() == 0) begin
            $display("%0t: result with nothing expected: count %h status %0d",
                     $time, rsp_chan.count_value, rsp_chan.status);
            failed = 1'b1;
         end else begin
            exp_res = pending_counts.pop_front();
            if (rsp_chan.count_value !== exp_res.count_value) begin
               $display("%0t: count_value mismatch: expected %h actual %h",
                        $time, exp_res.count_value, rsp_chan.count_value);
               failed = 1'b1;
            end
            if (rsp_chan.status !== exp_res.status) begin
               $display("%0t: status mismatch: expected %0d actual %0d",
                        $time, exp_res.status, rsp_chan.status);
               failed = 1'b1;
            end
         end
      end
   end

   // Ends the run when nothing is accepted on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, pending_counts.size());
         $display("escape_time_count_smoothing verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------
   // Tests.
   // ---------------------------------------------------------------------------

   // Discrete mode, including the unused mode value that behaves as discrete.
   task automatic test_discrete;
      send_item(16'd0, 32'd0);
      send_item(16'hFFFF, 32'hFFFF_FFFF);
      send_item(16'd37, 32'h0003_8000);
      set_config(2'd3, 32'd131072, 48'd262144, 32'sd45426, 32'sd45426);
      send_item(16'hFFFF, 32'h0001_0000);
      send_item(16'd1, 32'hFFFF_FFFF);
   endtask

   // Continuous mode, with a zero divisor and with a result beyond the low end of the range.
   task automatic test_continuous;
      set_config(MODE_CONTINUOUS, 32'd131072, 48'd262144, 32'sd45426, 32'sd45426);
      send_item(16'd12, 32'h0003_0000);
      send_item(16'd12, 32'h0000_0000);
      send_item(16'hFFFF, 32'hFFFF_FFFF);
      set_config(MODE_CONTINUOUS, 32'd0, 48'd1, 32'sd45426, 32'sd45426);
      send_item(16'd0, 32'hFFFF_FFFF);
      set_config(MODE_CONTINUOUS, 32'hFFFF_FFFE, 48'hFFFF_FFFF_FFFF, 32'sd45426, 32'sd45426);
      send_item(16'hFFFF, 32'd0);
      set_config(MODE_CONTINUOUS, 32'h0004_0000, 48'h0004_0000, 32'sd45426, 32'sd45426);
      send_item(16'd5, 32'h0005_0000);
   endtask

   // Smooth mode: the ordinary case and each error case.
   task automatic test_smooth;
      set_config(MODE_SMOOTH, 32'd131072, 48'd262144, 32'sd45426, 32'sd45426);
      send_item(16'd20, 32'h0002_8000);
      send_item(16'd20, 32'd0);            // Zero radius is outside the log domain.
      send_item(16'd20, 32'h0001_0000);    // A radius of one has a zero log.
      send_item(16'd20, 32'h0000_8000);    // Log of the radius has the other sign.
      send_item(16'hFFFF, 32'hFFFF_FFFF);
      send_item(16'd3, 32'd1);
      set_config(MODE_SMOOTH, 32'd131072, 48'd262144, 32'sd0, 32'sd45426);
      send_item(16'd4, 32'h0002_8000);     // Zero log of the escape radius.
      set_config(MODE_SMOOTH, 32'd131072, 48'd262144, 32'sd45426, 32'sd0);
      send_item(16'd4, 32'h0002_8000);     // Zero log of the power.
      set_config(MODE_SMOOTH, 32'd131072, 48'd262144, -32'sd45426, -32'sd1);
      send_item(16'd4, 32'h0000_4000);     // Both logs negative, negative power log.
      set_config(MODE_SMOOTH, 32'd131072, 48'd262144, 32'h7FFF_FFFF, 32'd1);
      send_item(16'hFFFF, 32'h0001_0001);
      set_config(MODE_SMOOTH, 32'd131072, 48'd262144, 32'h8000_0000, 32'h8000_0000);
      send_item(16'd0, 32'h0000_0001);
   endtask

   // Random phases, each with a fresh configuration. Most smooth phases use
   // sensible constants and radii near the escape radius so that the full
   // computation is reached; the rest hits the error and clamping paths.
   task automatic test_random;
      logic [31:0] radius;
      logic [31:0] log_radius;
      logic [31:0] log_p;
      logic [47:0] radius_pow;
      logic [1:0]  mode;
      logic [31:0] orbit;
      for (int phase = 0; phase < 12; phase++) begin
         mode = 2'($urandom_range(0, 3));
         if ($urandom_range(0, 3) == 0) begin
            radius     = $urandom();
            radius_pow = {16'($urandom()), 32'($urandom())};
            log_radius = $urandom();
            log_p      = $urandom();
         end else begin
            radius     = $urandom_range(32'h0001_8000, 32'h0100_0000);
            radius_pow = 48'(radius) * $urandom_range(2, 64);
            log_radius = $urandom_range(1000, 500000);
            log_p      = $urandom_range(20000, 200000);
            if ($urandom_range(0, 4) == 0) begin
               log_radius = -log_radius;
            end
            if ($urandom_range(0, 5) == 0) begin
               log_p = -log_p;
            end
         end
         steady_send = ($urandom_range(0, 3) == 0);
         steady_recv = ($urandom_range(0, 3) == 0);
         set_config(mode, radius, radius_pow, log_radius, log_p);
         for (int n = 0; n < 80; n++) begin
            case ($urandom_range(0, 3))
               0:       orbit = $urandom();
               1:       orbit = $urandom_range(32'd1, 32'h0001_0000);
               default: orbit = $urandom_range(radius, radius + (radius >> 1));
            endcase
            if (log_radius[31] && mode == MODE_SMOOTH && $urandom_range(0, 1) == 0) begin
               orbit = $urandom_range(32'd1, 32'h0000_FFFF);
            end
            send_item(16'($urandom_range(0, 16'hFFFF)), orbit);
         end
      end
      steady_send = 1'b0;
      steady_recv = 1'b0;
   endtask

   initial begin
      steady_send    = 1'b0;
      steady_recv    = 1'b0;
      burst_left     = 0;
      reset          = 1'b1;
      csr_write_en   = 1'b0;
      csr_index      = CSR_MODE;
      csr_write_data = '0;
      req_chan.valid        = 1'b0;
      req_chan.iter_count   = '0;
      req_chan.orbit_radius = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_discrete();
      test_continuous();
      test_smooth();
      test_random();

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (!failed && pending_counts.size() == 0) begin
         $display("escape_time_count_smoothing verification clean");
      end else begin
         $display("escape_time_count_smoothing verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

[files.f]
hdl/etcs_pkg.sv
hdl/etcs_req_if.sv
hdl/etcs_rsp_if.sv
hdl/etcs_sq_cell.sv
hdl/etcs_log.sv
hdl/etcs_div_cell.sv
hdl/etcs_div.sv
hdl/escape_time_count_smoothing.sv
sim/tb_escape_time_count_smoothing.sv
